// File: hw/rtl/mti_pkg.sv
`default_nettype none
package mti_pkg;

  localparam int MAX_DIMS    = 3;
  localparam int AXIS_MAX    = 16;
  localparam int COLUMNS_MAX = 4;
  localparam int AXIS_DEPTH  = MAX_DIMS * AXIS_MAX;
  localparam int GRID_DEPTH  = 16384;
  localparam int CORNERS     = 8;

  typedef logic [3:0] state_t;

  // sequencer states
  localparam state_t S_IDLE  = 4'd0;
  localparam state_t S_SRCH  = 4'd1;
  localparam state_t S_SWAIT = 4'd2;
  localparam state_t S_GATH  = 4'd3;
  localparam state_t S_GWR   = 4'd4;
  localparam state_t S_AX1   = 4'd5;
  localparam state_t S_AX2   = 4'd6;
  localparam state_t S_AX3   = 4'd7;
  localparam state_t S_BV0   = 4'd8;
  localparam state_t S_BV1   = 4'd9;
  localparam state_t S_BV2   = 4'd10;
  localparam state_t S_MUL   = 4'd11;
  localparam state_t S_DPREP = 4'd12;
  localparam state_t S_DIV   = 4'd13;
  localparam state_t S_WB    = 4'd14;
  localparam state_t S_OUTW  = 4'd15;

  // commands
  localparam logic [1:0] CMD_LOAD_AXIS = 2'd0;
  localparam logic [1:0] CMD_LOAD_DATA = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  // register indexes
  localparam logic [2:0] REG_DIMS   = 3'd0;
  localparam logic [2:0] REG_LEN0   = 3'd1;
  localparam logic [2:0] REG_LEN1   = 3'd2;
  localparam logic [2:0] REG_LEN2   = 3'd3;
  localparam logic [2:0] REG_NVAL   = 3'd4;

endpackage
`default_nettype wire

// File: hw/rtl/mti_ram.sv
`default_nettype none
module mti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hw/rtl/multilinear_table_interpolator.sv
`default_nettype none
// Multilinear table interpolator, signed Q16.16. Load items (command 0 axis,
// command 1 grid) are taken one per cycle while no query is in progress and
// return nothing. A query item (command 2) stalls the input until its last
// column result has been taken. It bisects each axis in use (up to five
// probes per axis), then for each value column gathers 2^dims corners from
// the grid memory and runs 2^dims-1 blends through one shared unit: an
// 18x32 signed multiplier used four times to build the 66-bit numerator,
// then a radix-2 divider that retires one quotient bit per cycle. Each
// dimension also reads its two bracketing axis points, and the divider
// dominates the time of a blend. Equal bracketing axis points take the
// truncated average instead and skip the multiplier and divider.
// Coordinates outside an axis clamp to its end point. Entries of the axis
// and grid memories that were never written read as arbitrary data.
module multilinear_table_interpolator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic [13:0]        in_address,
  input  wire logic signed [31:0] in_load_value,
  input  wire logic signed [31:0] in_coord_first,
  input  wire logic signed [31:0] in_coord_second,
  input  wire logic signed [31:0] in_coord_third,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_value,
  output logic [1:0]              out_column,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [4:0]         cfg_wdata
);

  // configuration
  logic [1:0] dims_r;
  logic [4:0] len_r [3];
  logic [2:0] nval_r;
  logic [1:0] dims_eff;
  logic [4:0] len_eff [3];
  logic [2:0] nval_eff;

  // sequencer and datapath registers
  mti_pkg::state_t    state_r, state_nxt;
  logic [1:0]         k_r, k_nxt;
  logic signed [5:0]  jl_r, jl_nxt, ju_r, ju_nxt;
  logic [3:0]         jm_r, jm_nxt;
  logic [3:0]         lo_r [3];
  logic [3:0]         hi_r [3];
  logic [3:0]         lo_nxt [3];
  logic [3:0]         hi_nxt [3];
  logic signed [31:0] coord_r [3];
  logic [1:0]         col_r, col_nxt;
  logic [3:0]         m_r, m_nxt;
  logic [2:0]         width_r, width_nxt;
  logic signed [31:0] x1_r, x1_nxt, x2_r, x2_nxt, v1_r, v1_nxt, v2_r, v2_nxt;
  logic [32:0]        aa_r, aa_nxt, bb_r, bb_nxt;
  logic signed [65:0] acc_r, acc_nxt;
  logic [1:0]         mstep_r, mstep_nxt;
  logic [32:0]        rem_r, rem_nxt, dm_r, dm_nxt;
  logic [31:0]        q_r, q_nxt;
  logic               neg_r, neg_nxt;
  logic [4:0]         dcnt_r, dcnt_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic [1:0]         out_col_r, out_col_nxt;
  logic               out_last_r, out_last_nxt;

  // memory ports
  logic        axis_we, grid_we, corner_we;
  logic [5:0]  axis_raddr;
  logic [13:0] grid_raddr;
  logic [2:0]  corner_raddr, corner_waddr;
  logic [31:0] corner_wdata;
  logic [31:0] axis_rdata, grid_rdata, corner_rdata;

  // helpers
  logic [3:0]         jm_c;
  logic [5:0]         jsum;
  logic [11:0]        flat_f;
  logic [14:0]        flat_c;
  logic [1:0]         bsel;
  logic [3:0]         ncorners;
  logic [4:0]         len_m1;
  logic signed [31:0] xmin, xmax, cc;
  logic signed [32:0] avg_s;
  logic [17:0]        apart;
  logic signed [31:0] bop;
  logic signed [49:0] prod;
  logic signed [65:0] addend;
  logic signed [32:0] dd;
  logic [65:0]        nm;
  logic [33:0]        dtry;
  logic               dge;
  logic [33:0]        dsub;
  logic [31:0]        qfin;

  // out-of-range register values saturate
  always_comb begin
    dims_eff = (dims_r == 2'd0) ? 2'd1 : dims_r;
    nval_eff = (nval_r == 3'd0) ? 3'd1 :
               (nval_r > 3'(mti_pkg::COLUMNS_MAX)) ? 3'(mti_pkg::COLUMNS_MAX) : nval_r;
    for (int i = 0; i < 3; i++) begin
      len_eff[i] = (len_r[i] == 5'd0) ? 5'd1 :
                   (len_r[i] > 5'(mti_pkg::AXIS_MAX)) ? 5'(mti_pkg::AXIS_MAX) : len_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 2'd1;
      len_r[0] <= 5'd16;
      len_r[1] <= 5'd16;
      len_r[2] <= 5'd16;
      nval_r <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        mti_pkg::REG_DIMS: dims_r   <= cfg_wdata[1:0];
        mti_pkg::REG_LEN0: len_r[0] <= cfg_wdata;
        mti_pkg::REG_LEN1: len_r[1] <= cfg_wdata;
        mti_pkg::REG_LEN2: len_r[2] <= cfg_wdata;
        mti_pkg::REG_NVAL: nval_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // bisection midpoint
  assign jsum = 6'(jl_r + ju_r);
  assign jm_c = jsum[4:1];

  // flat grid address of corner m, column col (row-major, wraps)
  always_comb begin
    flat_f = 12'd0;
    for (int k = 0; k < 3; k++) begin
      bsel = 2'(int'(dims_eff) - 1 - k);
      if (k < int'(dims_eff)) begin
        flat_f = 12'(flat_f * len_eff[k]) + 12'(m_r[bsel] ? hi_r[k] : lo_r[k]);
      end
    end
    flat_c = 15'(flat_f * nval_eff) + 15'(col_r);
  end
  assign grid_raddr = flat_c[13:0];
  assign ncorners = 4'd1 << dims_eff;
  assign len_m1 = len_eff[k_r] - 5'd1;

  // clamp of the coordinate into the bracket, and the equal-point average
  always_comb begin
    xmin = (x1_r < x2_r) ? x1_r : x2_r;
    xmax = (x1_r < x2_r) ? x2_r : x1_r;
    cc = coord_r[k_r];
    if (cc < xmin) cc = xmin;
    if (cc > xmax) cc = xmax;
    avg_s = 33'({v1_r[31], v1_r} + {corner_rdata[31], corner_rdata});
    avg_s = (avg_s + 33'(avg_s[32])) >>> 1;
  end

  // shared multiplier: one slice of a signed difference times a value;
  // low slice is unsigned, high slice carries the sign
  always_comb begin
    case (mstep_r)
      2'd0: begin apart = {1'b0, aa_r[16:0]};              bop = v2_r; end
      2'd1: begin apart = {{2{aa_r[32]}}, aa_r[32:17]};    bop = v2_r; end
      2'd2: begin apart = {1'b0, bb_r[16:0]};              bop = v1_r; end
      default: begin apart = {{2{bb_r[32]}}, bb_r[32:17]}; bop = v1_r; end
    endcase
    prod = $signed(apart) * bop;
    addend = 66'(prod);
    if (mstep_r[0]) addend = addend <<< 17;
  end

  // divider setup and step
  assign dd = $signed({x2_r[31], x2_r}) - $signed({x1_r[31], x1_r});
  assign nm = acc_r[65] ? 66'(-acc_r) : 66'(acc_r);
  assign dtry = {rem_r, q_r[31]};
  assign dge = dtry >= {1'b0, dm_r};
  assign dsub = dge ? dtry - {1'b0, dm_r} : dtry;
  assign qfin = {q_r[30:0], dge};

  always_comb begin
    state_nxt = state_r; k_nxt = k_r; jl_nxt = jl_r; ju_nxt = ju_r; jm_nxt = jm_r;
    for (int i = 0; i < 3; i++) begin
      lo_nxt[i] = lo_r[i];
      hi_nxt[i] = hi_r[i];
    end
    col_nxt = col_r; m_nxt = m_r; width_nxt = width_r;
    x1_nxt = x1_r; x2_nxt = x2_r; v1_nxt = v1_r; v2_nxt = v2_r;
    aa_nxt = aa_r; bb_nxt = bb_r; acc_nxt = acc_r; mstep_nxt = mstep_r;
    rem_nxt = rem_r; dm_nxt = dm_r; q_nxt = q_r; neg_nxt = neg_r; dcnt_nxt = dcnt_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r; out_value_nxt = out_value_r;
    out_col_nxt = out_col_r; out_last_nxt = out_last_r;
    axis_we = 1'b0; grid_we = 1'b0; corner_we = 1'b0;
    axis_raddr = {k_r, jm_c};
    corner_raddr = {m_r[1:0], 1'b0};
    corner_waddr = m_r[2:0];
    corner_wdata = grid_rdata;

    case (state_r)
      mti_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            mti_pkg::CMD_LOAD_AXIS: axis_we = in_address < 14'(mti_pkg::AXIS_DEPTH);
            mti_pkg::CMD_LOAD_DATA: grid_we = 1'b1;
            mti_pkg::CMD_QUERY: begin
              k_nxt = 2'd0;
              jl_nxt = -6'sd1;
              ju_nxt = $signed({1'b0, len_eff[0]});
              col_nxt = 2'd0;
              state_nxt = mti_pkg::S_SRCH;
            end
            default: ;
          endcase
        end
      end
      mti_pkg::S_SRCH: begin
        if (ju_r - jl_r > 6'sd1) begin
          jm_nxt = jm_c;
          state_nxt = mti_pkg::S_SWAIT;
        end else begin
          if (jl_r < 6'sd0) begin
            lo_nxt[k_r] = 4'd0;
            hi_nxt[k_r] = 4'd0;
          end else if (jl_r >= $signed({1'b0, len_m1})) begin
            lo_nxt[k_r] = len_m1[3:0];
            hi_nxt[k_r] = len_m1[3:0];
          end else begin
            lo_nxt[k_r] = jl_r[3:0];
            hi_nxt[k_r] = 4'(jl_r[3:0] + 4'd1);
          end
          if (k_r == dims_eff - 2'd1) begin
            m_nxt = 4'd0;
            state_nxt = mti_pkg::S_GATH;
          end else begin
            k_nxt = k_r + 2'd1;
            jl_nxt = -6'sd1;
            ju_nxt = $signed({1'b0, len_eff[k_r + 2'd1]});
          end
        end
      end
      mti_pkg::S_SWAIT: begin
        if (coord_r[k_r] >= $signed(axis_rdata)) jl_nxt = $signed({2'b00, jm_r});
        else ju_nxt = $signed({2'b00, jm_r});
        state_nxt = mti_pkg::S_SRCH;
      end
      mti_pkg::S_GATH: state_nxt = mti_pkg::S_GWR;
      mti_pkg::S_GWR: begin
        corner_we = 1'b1;
        if (m_r + 4'd1 == ncorners) begin
          k_nxt = dims_eff - 2'd1;
          width_nxt = 3'd1 << (dims_eff - 2'd1);
          m_nxt = 4'd0;
          state_nxt = mti_pkg::S_AX1;
        end else begin
          m_nxt = m_r + 4'd1;
          state_nxt = mti_pkg::S_GATH;
        end
      end
      mti_pkg::S_AX1: begin
        axis_raddr = {k_r, lo_r[k_r]};
        state_nxt = mti_pkg::S_AX2;
      end
      mti_pkg::S_AX2: begin
        axis_raddr = {k_r, hi_r[k_r]};
        x1_nxt = axis_rdata;
        state_nxt = mti_pkg::S_AX3;
      end
      mti_pkg::S_AX3: begin
        x2_nxt = axis_rdata;
        state_nxt = mti_pkg::S_BV0;
      end
      mti_pkg::S_BV0: begin
        corner_raddr = {m_r[1:0], 1'b0};
        state_nxt = mti_pkg::S_BV1;
      end
      mti_pkg::S_BV1: begin
        corner_raddr = {m_r[1:0], 1'b1};
        v1_nxt = corner_rdata;
        state_nxt = mti_pkg::S_BV2;
      end
      mti_pkg::S_BV2: begin
        if (x1_r == x2_r) begin
          res_nxt = avg_s[31:0];
          state_nxt = mti_pkg::S_WB;
        end else begin
          v2_nxt = corner_rdata;
          aa_nxt = 33'($signed({cc[31], cc}) - $signed({x1_r[31], x1_r}));
          bb_nxt = 33'($signed({x2_r[31], x2_r}) - $signed({cc[31], cc}));
          acc_nxt = 66'sd0;
          mstep_nxt = 2'd0;
          state_nxt = mti_pkg::S_MUL;
        end
      end
      mti_pkg::S_MUL: begin
        acc_nxt = acc_r + addend;
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd3) state_nxt = mti_pkg::S_DPREP;
      end
      mti_pkg::S_DPREP: begin
        // quotient magnitude is at most 2^31, so the upper half stays below the divisor
        rem_nxt = nm[64:32];
        q_nxt = nm[31:0];
        dm_nxt = dd[32] ? 33'(-dd) : 33'(dd);
        neg_nxt = acc_r[65] ^ dd[32];
        dcnt_nxt = 5'd0;
        state_nxt = mti_pkg::S_DIV;
      end
      mti_pkg::S_DIV: begin
        rem_nxt = dsub[32:0];
        q_nxt = qfin;
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          res_nxt = neg_r ? -$signed(qfin) : $signed(qfin);
          state_nxt = mti_pkg::S_WB;
        end
      end
      mti_pkg::S_WB: begin
        corner_we = 1'b1;
        corner_wdata = res_r;
        if (m_r + 4'd1 == {1'b0, width_r}) begin
          if (k_r == 2'd0) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = res_r;
            out_col_nxt = col_r;
            out_last_nxt = {1'b0, col_r} == nval_eff - 3'd1;
            state_nxt = mti_pkg::S_OUTW;
          end else begin
            k_nxt = k_r - 2'd1;
            width_nxt = width_r >> 1;
            m_nxt = 4'd0;
            state_nxt = mti_pkg::S_AX1;
          end
        end else begin
          m_nxt = m_r + 4'd1;
          state_nxt = mti_pkg::S_BV0;
        end
      end
      mti_pkg::S_OUTW: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          m_nxt = 4'd0;
          if (out_last_r) begin
            state_nxt = mti_pkg::S_IDLE;
          end else begin
            col_nxt = col_r + 2'd1;
            state_nxt = mti_pkg::S_GATH;
          end
        end
      end
      default: state_nxt = mti_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mti_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mti_pkg::S_IDLE && in_valid && in_command == mti_pkg::CMD_QUERY) begin
      coord_r[0] <= in_coord_first;
      coord_r[1] <= in_coord_second;
      coord_r[2] <= in_coord_third;
    end
    k_r <= k_nxt; jl_r <= jl_nxt; ju_r <= ju_nxt; jm_r <= jm_nxt;
    for (int i = 0; i < 3; i++) begin
      lo_r[i] <= lo_nxt[i];
      hi_r[i] <= hi_nxt[i];
    end
    col_r <= col_nxt; m_r <= m_nxt; width_r <= width_nxt;
    x1_r <= x1_nxt; x2_r <= x2_nxt; v1_r <= v1_nxt; v2_r <= v2_nxt;
    aa_r <= aa_nxt; bb_r <= bb_nxt; acc_r <= acc_nxt; mstep_r <= mstep_nxt;
    rem_r <= rem_nxt; dm_r <= dm_nxt; q_r <= q_nxt; neg_r <= neg_nxt; dcnt_r <= dcnt_nxt;
    res_r <= res_nxt;
    out_value_r <= out_value_nxt; out_col_r <= out_col_nxt; out_last_r <= out_last_nxt;
  end

  mti_ram #(.WIDTH(32), .DEPTH(mti_pkg::AXIS_DEPTH)) u_axis (
    .clk(clk), .we(axis_we), .waddr(in_address[5:0]), .wdata(in_load_value),
    .raddr(axis_raddr), .rdata(axis_rdata)
  );

  mti_ram #(.WIDTH(32), .DEPTH(mti_pkg::GRID_DEPTH)) u_grid (
    .clk(clk), .we(grid_we), .waddr(in_address), .wdata(in_load_value),
    .raddr(grid_raddr), .rdata(grid_rdata)
  );

  mti_ram #(.WIDTH(32), .DEPTH(mti_pkg::CORNERS)) u_corner (
    .clk(clk), .we(corner_we), .waddr(corner_waddr), .wdata(corner_wdata),
    .raddr(corner_raddr), .rdata(corner_rdata)
  );

  assign in_stall = state_r != mti_pkg::S_IDLE;
  assign out_valid = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_column = out_col_r;
  assign out_last = out_last_r;

  // input is only open with no result pending
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("input open while result pending");

  // divider partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mti_pkg::S_DIV |-> rem_r < dm_r) else $error("divider remainder overflow");

  // last flag marks the final column
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> {1'b0, out_column} == nval_eff - 3'd1)
    else $error("last flag on wrong column");

  // a probe only happens with an open bracket
  a_search: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mti_pkg::S_SWAIT |-> jl_r < ju_r) else $error("search bracket collapsed");

endmodule
`default_nettype wire
